>>> rtl/core/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types for the two-class priority queue
// Operation and status codes, sequencer states, control and status bundles.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_PEEK = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic write;
    logic read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_enq;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/tcpq_in_if.sv
// ----------------------------------------------------------------------------
// tcpq_in_if: operation channel
// Valid/ready channel carrying one queue operation word.
// ----------------------------------------------------------------------------
interface tcpq_in_if #(
  parameter int TIME_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic                 is_vip;
  logic [TIME_BITS-1:0] arrival_time;
  logic [TIME_BITS-1:0] departure_time;

  modport source (output valid, func, is_vip, arrival_time, departure_time, input ready);
  modport sink   (input valid, func, is_vip, arrival_time, departure_time, output ready);
endinterface

>>> rtl/core/tcpq_out_if.sv
// ----------------------------------------------------------------------------
// tcpq_out_if: result channel
// Valid/ready channel carrying one result word per operation.
// ----------------------------------------------------------------------------
interface tcpq_out_if #(
  parameter int TIME_BITS = 16,
  parameter int CNT_W     = 6
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [TIME_BITS-1:0] head_arrival;
  logic [TIME_BITS-1:0] head_departure;
  logic                 head_vip;
  logic [CNT_W-1:0]     entry_count;

  modport source (output valid, status, head_arrival, head_departure, head_vip,
                  entry_count, input ready);
  modport sink   (input valid, status, head_arrival, head_departure, head_vip,
                  entry_count, output ready);
endinterface

>>> rtl/core/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// tcpq_ctrl: operation sequencer
// Steps each operation through write (enqueue only), head read and result load.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  tcpq_pkg::sts_t sts,
  output tcpq_pkg::cmd_t cmd,
  output logic          in_ready
);

  tcpq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcpq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      tcpq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.in_enq ? tcpq_pkg::ST_WRITE : tcpq_pkg::ST_READ;
        end
      end
      tcpq_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = tcpq_pkg::ST_READ;
      end
      tcpq_pkg::ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = tcpq_pkg::ST_DONE;
      end
      tcpq_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = tcpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcpq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/tcpq_dp.sv
// ----------------------------------------------------------------------------
// tcpq_dp: queue datapath
// Two class stores with pointers and counts, head select and result register.
// ----------------------------------------------------------------------------
module tcpq_dp #(
  parameter int CLASS_DEPTH = 16,
  parameter int TIME_BITS   = 16,
  parameter int PTR_W       = $clog2(CLASS_DEPTH),
  parameter int CNT_W       = $clog2(CLASS_DEPTH + 1),
  parameter int TOT_W       = $clog2(2 * CLASS_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcpq_pkg::cmd_t       cmd,
  output tcpq_pkg::sts_t       sts,
  input  logic                 in_valid,
  input  logic [1:0]           in_func,
  input  logic                 in_is_vip,
  input  logic [TIME_BITS-1:0] in_arrival_time,
  input  logic [TIME_BITS-1:0] in_departure_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [TIME_BITS-1:0] out_head_arrival,
  output logic [TIME_BITS-1:0] out_head_departure,
  output logic                 out_head_vip,
  output logic [TOT_W-1:0]     out_entry_count
);

  localparam int ENT_W = 2 * TIME_BITS;

  logic [ENT_W-1:0] vip_mem_r  [CLASS_DEPTH];
  logic [ENT_W-1:0] norm_mem_r [CLASS_DEPTH];

  logic [1:0]           func_r;
  logic                 is_vip_r;
  logic [ENT_W-1:0]     entry_r;
  logic                 full_r;
  logic                 empty_r;
  logic                 sel_vip_r;
  logic [ENT_W-1:0]     vip_rd_r, norm_rd_r;

  logic [PTR_W-1:0] vip_rptr_r, vip_wptr_r, norm_rptr_r, norm_wptr_r;
  logic [CNT_W-1:0] vip_cnt_r, norm_cnt_r;

  logic                 out_valid_r;
  logic [1:0]           status_r;
  logic [TIME_BITS-1:0] head_arr_r, head_dep_r;
  logic                 head_vip_r;
  logic [TOT_W-1:0]     count_r;

  logic             vip_full, norm_full, do_deq, wr_vip, wr_norm;
  logic [ENT_W-1:0] head_ent;
  logic [TOT_W-1:0] count_nxt;
  logic [1:0]       status_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign vip_full  = (vip_cnt_r == CNT_W'(CLASS_DEPTH));
  assign norm_full = (norm_cnt_r == CNT_W'(CLASS_DEPTH));
  assign wr_vip    = cmd.write && is_vip_r && !vip_full;
  assign wr_norm   = cmd.write && !is_vip_r && !norm_full;
  assign do_deq    = cmd.load_out && (func_r == tcpq_pkg::FUNC_DEQ) && !empty_r;

  assign head_ent  = sel_vip_r ? vip_rd_r : norm_rd_r;
  assign count_nxt = TOT_W'(vip_cnt_r) + TOT_W'(norm_cnt_r) - TOT_W'(do_deq);

  always_comb begin
    if (full_r) begin
      status_nxt = tcpq_pkg::STS_FULL;
    end else if (empty_r && (func_r != tcpq_pkg::FUNC_ENQ)) begin
      status_nxt = tcpq_pkg::STS_EMPTY;
    end else begin
      status_nxt = tcpq_pkg::STS_OK;
    end
  end

  assign sts.in_valid = in_valid;
  assign sts.in_enq   = (in_func == tcpq_pkg::FUNC_ENQ);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (wr_vip) begin
      vip_mem_r[vip_wptr_r] <= entry_r;
    end
    if (wr_norm) begin
      norm_mem_r[norm_wptr_r] <= entry_r;
    end
    if (cmd.read) begin
      vip_rd_r  <= vip_mem_r[vip_rptr_r];
      norm_rd_r <= norm_mem_r[norm_rptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= in_func;
      is_vip_r <= in_is_vip;
      entry_r  <= {in_arrival_time, in_departure_time};
    end
    if (cmd.read) begin
      sel_vip_r <= (vip_cnt_r != '0);
      empty_r   <= (vip_cnt_r == '0) && (norm_cnt_r == '0);
    end
    if (cmd.load_out) begin
      status_r   <= status_nxt;
      head_arr_r <= empty_r ? '0 : head_ent[ENT_W-1:TIME_BITS];
      head_dep_r <= empty_r ? '0 : head_ent[TIME_BITS-1:0];
      head_vip_r <= !empty_r && sel_vip_r;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vip_rptr_r  <= '0;
      vip_wptr_r  <= '0;
      vip_cnt_r   <= '0;
      norm_rptr_r <= '0;
      norm_wptr_r <= '0;
      norm_cnt_r  <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        full_r <= 1'b0;
      end
      if (cmd.write) begin
        full_r <= is_vip_r ? vip_full : norm_full;
      end
      if (wr_vip) begin
        vip_wptr_r <= ptr_inc(vip_wptr_r);
        vip_cnt_r  <= vip_cnt_r + 1'b1;
      end
      if (wr_norm) begin
        norm_wptr_r <= ptr_inc(norm_wptr_r);
        norm_cnt_r  <= norm_cnt_r + 1'b1;
      end
      if (do_deq && sel_vip_r) begin
        vip_rptr_r <= ptr_inc(vip_rptr_r);
        vip_cnt_r  <= vip_cnt_r - 1'b1;
      end
      if (do_deq && !sel_vip_r) begin
        norm_rptr_r <= ptr_inc(norm_rptr_r);
        norm_cnt_r  <= norm_cnt_r - 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_head_arrival   = head_arr_r;
  assign out_head_departure = head_dep_r;
  assign out_head_vip       = head_vip_r;
  assign out_entry_count    = count_r;

endmodule

>>> rtl/core/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue: strict-priority queue over two class FIFOs
// Each word is accepted, then stepped through store write (enqueue only),
//   registered store read and result load; the next word is accepted only
//   after result load, which waits while the result register is held.
// The result register lets the next word be taken while a result waits.
// Reset (rst_n low, synchronous) empties both classes; stores are not cleared.
// ----------------------------------------------------------------------------
module two_class_priority_queue #(
  parameter int CLASS_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  tcpq_in_if.sink      in_ch,
  tcpq_out_if.source   out_ch
);

  tcpq_pkg::cmd_t cmd;
  tcpq_pkg::sts_t sts;

  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ch.ready)
  );

  tcpq_dp #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_valid           (in_ch.valid),
    .in_func            (in_ch.func),
    .in_is_vip          (in_ch.is_vip),
    .in_arrival_time    (in_ch.arrival_time),
    .in_departure_time  (in_ch.departure_time),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_head_arrival   (out_ch.head_arrival),
    .out_head_departure (out_ch.head_departure),
    .out_head_vip       (out_ch.head_vip),
    .out_entry_count    (out_ch.entry_count)
  );

endmodule
